>>> sv/urxfp_pkg.sv
// Shared types and constants for the UART receive FIFO and reply parser.
// Used by urxfp_fifo, urxfp_reply and uart_rx_fifo_and_reply_parser; no dependencies.
package urxfp_pkg;

    // item kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // parser characters
    localparam logic [7:0] CH_START = 8'h3C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ERR   = 8'h45;
    localparam logic [7:0] CH_OK    = 8'h53;

    // reply codes
    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_ERR  = 2'd1;
    localparam logic [1:0] CODE_OK   = 2'd2;

    // line end tracking
    localparam logic [1:0] LE_NONE = 2'd0;
    localparam logic [1:0] LE_CR   = 2'd1;
    localparam logic [1:0] LE_LF   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic       rx_error;
        logic [5:0] reply_index;
    } in_item_t;

    typedef struct packed {
        logic       pop_valid;
        logic [7:0] pop_byte;
        logic [6:0] fifo_level;
        logic       overflow_seen;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic [1:0] reply_code;
        logic       reply_ready;
        logic [6:0] reply_length;
        logic [7:0] reply_byte;
    } out_item_t;

    typedef struct packed {
        logic       pop_valid;
        logic [7:0] pop_byte;
        logic [6:0] fifo_level;
        logic       overflow_seen;
    } fifo_res_t;

    typedef struct packed {
        logic [1:0] reply_code;
        logic       reply_ready;
        logic [6:0] reply_length;
        logic [7:0] reply_byte;
    } reply_res_t;

endpackage

>>> sv/urxfp_fifo.sv
// Circular receive FIFO with sticky overflow; one item per cycle while take is high.
// Depends on urxfp_pkg.
module urxfp_fifo #(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  urxfp_pkg::in_item_t  item,
    input  logic                 command_mode,
    output urxfp_pkg::fifo_res_t res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          pop_valid_reg;
    logic [7:0]    pop_data_reg;
    logic          push, pop;

    always_comb
    begin
        push       = (item.kind == urxfp_pkg::KIND_BYTE) && !item.rx_error && !command_mode;
        pop        = (item.kind == urxfp_pkg::KIND_POP) && (count_reg != '0);
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            // reaching depth throws the buffered data away
            if (count_reg == CW'(DEPTH - 1))
            begin
                count_next = '0;
                ovf_next   = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (pop)
        begin
            rp_next    = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (item.kind == urxfp_pkg::KIND_CLEAR)
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pop_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pop_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && push)
        begin
            mem[wp_reg] <= item.rx_byte;
        end
        if (take && pop)
        begin
            pop_data_reg <= mem[rp_reg];
        end
    end

    // state only moves on a new beat, so it still matches the held result
    always_comb
    begin
        res.pop_valid     = pop_valid_reg;
        res.pop_byte      = pop_valid_reg ? pop_data_reg : 8'h00;
        res.fifo_level    = 7'(count_reg);
        res.overflow_seen = ovf_reg;
    end

endmodule

>>> sv/urxfp_reply.sv
// Command-mode reply parser with wrapping reply buffer and indexed read.
// Depends on urxfp_pkg.
module urxfp_reply #(
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  urxfp_pkg::in_item_t   item,
    input  logic                  command_mode,
    output urxfp_pkg::reply_res_t res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (PW > 6) ? PW : 6;

    logic [7:0]    mem [DEPTH];
    logic [CW-1:0] count_reg, count_next, count_base;
    logic          started_reg, started_next;
    logic [1:0]    code_reg, code_next;
    logic [1:0]    stage_reg, stage_next;
    logic          done_reg, done_next;
    logic          rd_hit_reg;
    logic [7:0]    rd_data_reg;
    logic          cmd_byte, store, has_code, rd, in_range;
    logic [IW-1:0] idx_ext;
    logic [7:0]    b;

    assign b        = item.rx_byte;
    assign idx_ext  = IW'(item.reply_index);
    assign in_range = 32'(item.reply_index) < 32'(DEPTH);
    assign rd       = (item.kind == urxfp_pkg::KIND_READ) && in_range;
    assign has_code = code_reg != urxfp_pkg::CODE_NONE;
    assign cmd_byte = (item.kind == urxfp_pkg::KIND_BYTE) && !item.rx_error && command_mode;
    // a full buffer wraps before the next byte is parsed
    assign count_base = (count_reg >= CW'(DEPTH)) ? '0 : count_reg;

    always_comb
    begin
        count_next   = count_reg;
        started_next = started_reg;
        code_next    = code_reg;
        stage_next   = stage_reg;
        done_next    = done_reg;
        store        = 1'b0;
        if (cmd_byte)
        begin
            count_next = count_base;
            if (b == urxfp_pkg::CH_START && !started_reg)
            begin
                started_next = 1'b1;
                code_next    = urxfp_pkg::CODE_NONE;
                done_next    = 1'b0;
            end
            else if (b == urxfp_pkg::CH_CR && stage_reg == urxfp_pkg::LE_NONE
                     && started_reg && has_code)
            begin
                stage_next = urxfp_pkg::LE_CR;
            end
            else if (b == urxfp_pkg::CH_LF && stage_reg == urxfp_pkg::LE_CR
                     && started_reg && has_code)
            begin
                stage_next = urxfp_pkg::LE_LF;
                done_next  = 1'b1;
            end
            else if (b == urxfp_pkg::CH_ERR && started_reg && !has_code)
            begin
                code_next = urxfp_pkg::CODE_ERR;
            end
            else if (b == urxfp_pkg::CH_OK && started_reg && !has_code)
            begin
                code_next = urxfp_pkg::CODE_OK;
            end
            else if (started_reg && has_code)
            begin
                store      = 1'b1;
                count_next = count_base + 1'b1;
            end
        end
        else if (item.kind == urxfp_pkg::KIND_CLEAR)
        begin
            count_next   = '0;
            started_next = 1'b0;
            code_next    = urxfp_pkg::CODE_NONE;
            stage_next   = urxfp_pkg::LE_NONE;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            started_reg <= 1'b0;
            code_reg    <= urxfp_pkg::CODE_NONE;
            stage_reg   <= urxfp_pkg::LE_NONE;
            done_reg    <= 1'b0;
            rd_hit_reg  <= 1'b0;
        end
        else if (take)
        begin
            count_reg   <= count_next;
            started_reg <= started_next;
            code_reg    <= code_next;
            stage_reg   <= stage_next;
            done_reg    <= done_next;
            rd_hit_reg  <= rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store)
        begin
            mem[count_base[PW-1:0]] <= b;
        end
        if (take && rd)
        begin
            rd_data_reg <= mem[idx_ext[PW-1:0]];
        end
    end

    always_comb
    begin
        res.reply_code   = code_reg;
        res.reply_ready  = done_reg;
        res.reply_length = 7'(count_reg);
        res.reply_byte   = rd_hit_reg ? rd_data_reg : 8'h00;
    end

endmodule

>>> sv/uart_rx_fifo_and_reply_parser.sv
// Top level: UART receive FIFO and command reply parser.
// Depends on urxfp_pkg, urxfp_fifo and urxfp_reply.
//
// Usage:
//   item channel (item_valid / item_stall / item): one beat per operation -
//     received byte with error flag, FIFO pop, reply byte read, or clear.
//   result channel (result_valid / result_stall / result): exactly one beat
//     per item, in order, carrying FIFO and parser status after that item.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes command_mode;
//     cfg_ready is always high. Write only while no item is in flight.
// Pipeline: an accepted item passes through two register stages: the state
//   update with its registered memory read, then the output register.
// Throughput: one item per cycle while result is not stalled; every pointer and
//   counter update is a single step and each buffer has one write and one read port.
// Stall: while result is stalled, one more item is still taken into the
//   first stage; item_stall rises only when both stages hold a beat.
// Reset: pointers, counters, parser state, flags (except the echo flag) and
//   command_mode clear; buffer contents are not cleared, no sweep is needed.
module uart_rx_fifo_and_reply_parser #(
    parameter int FIFO_DEPTH  = 64,
    parameter int REPLY_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  urxfp_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output urxfp_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    logic                  cmd_mode_reg;
    logic                  a_valid_reg, a_valid_next;
    logic                  b_valid_reg, b_valid_next;
    logic                  echo_valid_reg;
    logic [7:0]            echo_byte_reg;
    urxfp_pkg::out_item_t  b_data_reg, a_data;
    urxfp_pkg::fifo_res_t  fifo_res;
    urxfp_pkg::reply_res_t reply_res;
    logic                  take, a_move, echo;

    assign cfg_ready = 1'b1;

    assign a_move     = a_valid_reg && (!b_valid_reg || !result_stall);
    assign item_stall = a_valid_reg && !a_move;
    assign take       = item_valid && !item_stall;
    assign echo       = (item.kind == urxfp_pkg::KIND_BYTE) && !item.rx_error && cmd_mode_reg;

    assign a_valid_next = take || (a_valid_reg && !a_move);
    assign b_valid_next = a_move || (b_valid_reg && result_stall);

    urxfp_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (item),
        .command_mode (cmd_mode_reg),
        .res          (fifo_res)
    );

    urxfp_reply #(
        .DEPTH(REPLY_DEPTH)
    ) u_reply (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (item),
        .command_mode (cmd_mode_reg),
        .res          (reply_res)
    );

    always_comb
    begin
        a_data.pop_valid     = fifo_res.pop_valid;
        a_data.pop_byte      = fifo_res.pop_byte;
        a_data.fifo_level    = fifo_res.fifo_level;
        a_data.overflow_seen = fifo_res.overflow_seen;
        a_data.echo_valid    = echo_valid_reg;
        a_data.echo_byte     = echo_valid_reg ? echo_byte_reg : 8'h00;
        a_data.reply_code    = reply_res.reply_code;
        a_data.reply_ready   = reply_res.reply_ready;
        a_data.reply_length  = reply_res.reply_length;
        a_data.reply_byte    = reply_res.reply_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_mode_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cmd_mode_reg <= cfg_data;
            end
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            echo_valid_reg <= echo;
            echo_byte_reg  <= item.rx_byte;
        end
        if (a_move)
        begin
            b_data_reg <= a_data;
        end
    end

    assign result_valid = b_valid_reg;
    assign result       = b_data_reg;

endmodule
